### design/vprt_pkg.sv
`timescale 1ns / 1ps
// Package for the versioned pair rule table: item types, codes and the
// structs passed along the cell chain. Depends on nothing.
package vprt_pkg;

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_SAME    = 3'd1,
        ST_NEGFEE  = 3'd2,
        ST_STALE   = 3'd3,
        ST_FULL    = 3'd4,
        ST_MISSING = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        seller_zone;
        logic [15:0]        buyer_zone;
        logic               allowed_in;
        logic signed [31:0] fee_in;
        logic [31:0]        version_in;
        logic [62:0]        stamp_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic        allowed_out;
        logic [30:0] fee_out;
        logic [31:0] version_out;
        logic [62:0] stamp_out;
        logic [6:0]  entry_count;
    } t_rsp;

    // Search token and the state it gathers on its way down the chain.
    typedef struct packed {
        logic        tok;
        logic        hit;
        logic        free_seen;
        logic        allowed;
        logic [30:0] fee;
        logic [31:0] version;
        logic [62:0] stamp;
    } t_link;

    // Key and rule broadcast to every cell, with the commit enables.
    typedef struct packed {
        logic        wr_hit;
        logic        wr_free;
        logic        clr_hit;
        logic [15:0] seller;
        logic [15:0] buyer;
        logic        allowed;
        logic [30:0] fee;
        logic [31:0] version;
        logic [62:0] stamp;
    } t_cmd;

endpackage

### design/vprt_cell.sv
`timescale 1ns / 1ps
// One table entry of the rule chain. It compares the broadcast key as the
// search token passes and forwards the token. Depends on vprt_pkg.
module vprt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  vprt_pkg::t_cmd  i_cmd,
    input  vprt_pkg::t_link i_link,
    output vprt_pkg::t_link o_link
);

    logic            r_valid;
    logic            r_is_hit;
    logic            r_is_free;
    logic [15:0]     r_seller;
    logic [15:0]     r_buyer;
    logic            r_allowed;
    logic [30:0]     r_fee;
    logic [31:0]     r_version;
    logic [62:0]     r_stamp;
    vprt_pkg::t_link r_out;

    logic w_hit;
    logic w_write;

    assign w_hit = i_link.tok && r_valid && (r_seller == i_cmd.seller)
                   && (r_buyer == i_cmd.buyer);
    assign w_write = (i_cmd.wr_hit && r_is_hit) || (i_cmd.wr_free && r_is_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_is_hit  <= 1'b0;
            r_is_free <= 1'b0;
            r_out     <= '0;
        end else begin
            r_out.tok       <= i_link.tok;
            r_out.hit       <= i_link.hit || w_hit;
            r_out.free_seen <= i_link.free_seen || !r_valid;
            if (w_hit) begin
                r_out.allowed <= r_allowed;
                r_out.fee     <= r_fee;
                r_out.version <= r_version;
                r_out.stamp   <= r_stamp;
            end else begin
                r_out.allowed <= i_link.allowed;
                r_out.fee     <= i_link.fee;
                r_out.version <= i_link.version;
                r_out.stamp   <= i_link.stamp;
            end
            if (i_link.tok) begin
                r_is_hit  <= w_hit;
                r_is_free <= !r_valid && !i_link.free_seen;
            end
            if (w_write) begin
                r_valid <= 1'b1;
            end else if (i_cmd.clr_hit && r_is_hit) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_seller  <= i_cmd.seller;
            r_buyer   <= i_cmd.buyer;
            r_allowed <= i_cmd.allowed;
            r_fee     <= i_cmd.fee;
            r_version <= i_cmd.version;
            r_stamp   <= i_cmd.stamp;
        end
    end

    assign o_link = r_out;

endmodule

### design/versioned_pair_rule_table.sv
`timescale 1ns / 1ps
// Versioned pair rule table: a chain of entry cells with the command
// controller that launches searches and commits results. Depends on vprt_pkg.
//
// Usage. An item (upsert, remove or lookup of a seller/buyer zone pair) is
// taken on i_req at a rising edge where start is high and busy is low. The
// block then raises busy and sends a search token down a chain of
// TABLE_ENTRIES cells, one cell per cycle; each cell holds one rule and
// compares the key as the token passes, noting whether it holds the key and
// whether it is the lowest free slot. When the token leaves the last cell the
// controller decides the outcome, commits the write or removal to the chosen
// cell and registers the result. The result is held on o_rsp and o_done marks
// it for exactly one cycle; the receiver cannot stall it, so it must take it.
// busy is already low in that cycle, so a new item may be started there.
// A new item is taken only after the last one has committed, since the token
// walks the whole cell chain for each item. Each result sees every change
// made by the items before it. A synchronous reset (i_rst_n low) empties the
// table, clears the entry count and drops any item in flight; no clearing
// pass is needed, so the block is ready in the cycle after reset is released.
module versioned_pair_rule_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  vprt_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output vprt_pkg::t_rsp o_rsp
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic            r_launch;
    vprt_pkg::t_req  r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    vprt_pkg::t_rsp  n_rsp;

    vprt_pkg::t_cmd  w_cmd;
    vprt_pkg::t_link w_link [0:TABLE_ENTRIES];
    vprt_pkg::t_link w_tail;
    logic            w_accept;
    logic            w_commit;
    logic            w_same;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_tail   = w_link[TABLE_ENTRIES];
    assign w_commit = (r_state == S_SCAN) && w_tail.tok;
    assign w_same   = (r_req.seller_zone == r_req.buyer_zone);

    // The token enters the first cell in the cycle after the item is taken.
    always_comb begin
        w_link[0]           = '0;
        w_link[0].tok       = r_launch;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            vprt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_link  (w_link[g]),
                .o_link  (w_link[g+1])
            );
        end
    endgenerate

    // Decide the outcome once the token has visited every cell. The write
    // enables are only raised in the commit cycle; key and rule fields are
    // always driven from the held item.
    always_comb begin
        w_cmd         = '0;
        w_cmd.seller  = r_req.seller_zone;
        w_cmd.buyer   = r_req.buyer_zone;
        w_cmd.allowed = r_req.allowed_in;
        w_cmd.fee     = r_req.fee_in[30:0];
        w_cmd.version = r_req.version_in;
        w_cmd.stamp   = r_req.stamp_in;
        n_count       = r_count;
        n_rsp         = '0;
        n_rsp.status  = vprt_pkg::ST_DONE;

        case (r_req.op)
            vprt_pkg::OP_UPSERT: begin
                if (w_same) begin
                    n_rsp.status = vprt_pkg::ST_SAME;
                end else if (r_req.fee_in[31]) begin
                    n_rsp.status = vprt_pkg::ST_NEGFEE;
                end else if (w_tail.hit && (r_req.version_in <= w_tail.version)) begin
                    n_rsp.status = vprt_pkg::ST_STALE;
                end else if (w_tail.hit) begin
                    w_cmd.wr_hit = w_commit;
                end else if (!w_tail.free_seen) begin
                    n_rsp.status = vprt_pkg::ST_FULL;
                end else begin
                    // A new key takes the lowest free slot found by the walk.
                    w_cmd.wr_free = w_commit;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            vprt_pkg::OP_REMOVE: begin
                if (w_same) begin
                    n_rsp.status = vprt_pkg::ST_SAME;
                end else if (!w_tail.hit) begin
                    n_rsp.status = vprt_pkg::ST_MISSING;
                end else begin
                    w_cmd.clr_hit = w_commit;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            default: begin
                // Lookup; the unused op code behaves the same way.
                if (w_same) begin
                    n_rsp.found       = 1'b1;
                    n_rsp.allowed_out = 1'b1;
                end else if (!w_tail.hit) begin
                    n_rsp.status = vprt_pkg::ST_MISSING;
                end else begin
                    n_rsp.found       = 1'b1;
                    n_rsp.allowed_out = w_tail.allowed;
                    n_rsp.fee_out     = w_tail.fee;
                    n_rsp.version_out = w_tail.version;
                    n_rsp.stamp_out   = w_tail.stamp;
                end
            end
        endcase
        n_rsp.entry_count = 7'(n_count);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_count  <= '0;
            o_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_accept;
            o_done   <= w_commit;
            if (w_commit) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        if (w_commit) begin
            o_rsp <= n_rsp;
        end
    end

endmodule

### design/vprt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the versioned pair rule table, bound to the top
// level. Depends on vprt_pkg and versioned_pair_rule_table.
module vprt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input vprt_pkg::t_rsp o_rsp
);

    // A taken item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    // The result cycle is already free for a new item.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy high while a result is shown");

    // A result cycle is never directly followed by another.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe lasted more than one cycle");

    // A refused or missing outcome never reports a rule.
    a_fail_nofound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status != vprt_pkg::ST_DONE)) |-> !o_rsp.found)
        else $error("rule reported with a failing status");

    // Status stays within the defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rsp.status <= vprt_pkg::ST_MISSING))
        else $error("undefined status code");

endmodule

bind versioned_pair_rule_table vprt_checker u_vprt_checker (.*);
